[rtl/sqerr_pkg.sv]
// Shared constants, types and register codes of the squared-error loss unit.
package sqerr_pkg;

    localparam int MAX_COLS = 256;
    localparam int MAX_ROWS = 65536;

    localparam int IN_W    = 16;
    localparam int DIFF_W  = IN_W + 1;
    localparam int GRAD_W  = 18;
    localparam int LOSS_W  = 40;
    localparam int BATCH_W = 56;
    localparam int SQ_W    = 2 * DIFF_W - 1;

    localparam int LEN_W   = 9;
    localparam int CNT_W   = 17;
    localparam int SCALE_W = 18;
    localparam int CFG_W   = 18;
    localparam int IDX_W   = 2;

    localparam int COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROWP_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    localparam int MUL_W   = SCALE_W + 1;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int FRAC_W  = 16;

    localparam logic [LEN_W-1:0]   ROW_LENGTH_RST = LEN_W'(1);
    localparam logic [CNT_W-1:0]   ROW_COUNT_RST  = CNT_W'(1);
    localparam logic [SCALE_W-1:0] GRAD_SCALE_RST = SCALE_W'(131072);

    typedef enum logic [IDX_W-1:0] {
        CFG_ROW_LENGTH = 2'd0,
        CFG_ROW_COUNT  = 2'd1,
        CFG_GRAD_SCALE = 2'd2
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GRAD,
        S_SQR,
        S_ROW,
        S_BATCH,
        S_DIV,
        S_OUT
    } t_state;

endpackage

[rtl/sqerr_intf.sv]
// Stream interfaces carrying input elements and result items.
interface sqerr_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [sqerr_pkg::IN_W-1:0]    predicted;
    logic signed [sqerr_pkg::IN_W-1:0]    target;

    modport source (output valid, output predicted, output target, input ready);
    modport sink   (input valid, input predicted, input target, output ready);
endinterface

interface sqerr_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [sqerr_pkg::GRAD_W-1:0]  gradient;
    logic                                 row_done;
    logic        [sqerr_pkg::LOSS_W-1:0]  row_loss;
    logic                                 batch_done;
    logic        [sqerr_pkg::LOSS_W-1:0]  batch_mean;

    modport source (output valid, output gradient, output row_done, output row_loss,
                    output batch_done, output batch_mean, input ready);
    modport sink   (input valid, input gradient, input row_done, input row_loss,
                    input batch_done, input batch_mean, output ready);
endinterface

[rtl/sqerr_mul.sv]
// Shared signed multiplier with a registered product.
module sqerr_mul (
    input  logic                                  i_clk,
    input  logic signed [sqerr_pkg::MUL_W-1:0]    i_a,
    input  logic signed [sqerr_pkg::MUL_W-1:0]    i_b,
    output logic signed [sqerr_pkg::PROD_W-1:0]   o_prod
);

    logic signed [sqerr_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

[rtl/sqerr_div.sv]
// Restoring divider giving one quotient bit per cycle.
module sqerr_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [sqerr_pkg::BATCH_W-1:0]     i_dividend,
    input  logic [sqerr_pkg::CNT_W-1:0]       i_divisor,
    output logic                              o_done,
    output logic [sqerr_pkg::BATCH_W-1:0]     o_quotient
);

    localparam int STEP_W = $clog2(sqerr_pkg::BATCH_W);

    logic                              r_busy;
    logic                              r_done;
    logic [STEP_W-1:0]                 r_step;
    logic [sqerr_pkg::BATCH_W-1:0]     r_quo;
    logic [sqerr_pkg::CNT_W-1:0]       r_rem;
    logic [sqerr_pkg::CNT_W-1:0]       r_dvs;

    logic [sqerr_pkg::CNT_W:0]         shifted;
    logic [sqerr_pkg::CNT_W:0]         diff;
    logic                              ge;

    always_comb begin
        shifted = {r_rem, r_quo[sqerr_pkg::BATCH_W-1]};
        ge      = shifted >= {1'b0, r_dvs};
        diff    = shifted - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(sqerr_pkg::BATCH_W - 1);
            end else if (r_busy) begin
                r_step <= r_step - STEP_W'(1);
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[sqerr_pkg::BATCH_W-2:0], ge};
            r_rem <= ge ? diff[sqerr_pkg::CNT_W-1:0] : shifted[sqerr_pkg::CNT_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[rtl/squared_error_loss_and_gradient_unit.sv]
// Top level: sequencer, accumulators and output register of the loss unit.
//
//  Port      Dir  Kind          Carries
//  i_in      in   valid/ready   predicted, target (signed Q8.8)
//  o_out     out  valid/ready   gradient, row_done, row_loss, batch_done, batch_mean
//  i_cfg_*   in   write strobe  row_length, row_count, grad_scale
//
// An element passes through GRAD, SQR, ROW and OUT, plus BATCH when it ends a row
// and DIV when a batch ends: the shared multiplier forms the gradient product and
// then the square, and a one-bit-per-cycle divider (56 steps) gives the batch mean.
// Reset (synchronous, active low) clears the positions, both sums and the registers
// to their defaults. The input is ready only while the sequencer is idle; a result
// waits in the output register until its transfer, holding the sequencer if a
// further result is ready first.
module squared_error_loss_and_gradient_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    sqerr_in_if.sink                           i_in,
    sqerr_out_if.source                        o_out,
    input  logic                               i_cfg_we,
    input  logic [sqerr_pkg::IDX_W-1:0]        i_cfg_index,
    input  logic [sqerr_pkg::CFG_W-1:0]        i_cfg_data
);

    localparam int GSH_W = sqerr_pkg::PROD_W - sqerr_pkg::FRAC_W;

    sqerr_pkg::t_state r_state, n_state;

    logic [sqerr_pkg::LEN_W-1:0]    r_row_length;
    logic [sqerr_pkg::CNT_W-1:0]    r_row_count;
    logic [sqerr_pkg::SCALE_W-1:0]  r_grad_scale;

    logic [sqerr_pkg::COL_W-1:0]    r_col;
    logic [sqerr_pkg::ROWP_W-1:0]   r_rowp;
    logic [sqerr_pkg::LOSS_W-1:0]   r_row_acc;
    logic [sqerr_pkg::BATCH_W-1:0]  r_batch_acc;

    logic signed [sqerr_pkg::DIFF_W-1:0]  r_diff;
    logic signed [sqerr_pkg::GRAD_W-1:0]  r_grad;
    logic                                 r_row_end;
    logic [sqerr_pkg::LOSS_W-1:0]         r_row_loss;
    logic                                 r_batch_end;
    logic [sqerr_pkg::LOSS_W-1:0]         r_mean;

    logic                                 r_o_valid;
    logic signed [sqerr_pkg::GRAD_W-1:0]  r_o_grad;
    logic                                 r_o_row_done;
    logic [sqerr_pkg::LOSS_W-1:0]         r_o_row_loss;
    logic                                 r_o_batch_done;
    logic [sqerr_pkg::LOSS_W-1:0]         r_o_mean;

    logic signed [sqerr_pkg::MUL_W-1:0]   mul_a, mul_b;
    logic signed [sqerr_pkg::PROD_W-1:0]  prod;
    logic                                 div_start, div_done;
    logic [sqerr_pkg::BATCH_W-1:0]        div_quo;

    logic [sqerr_pkg::LEN_W-1:0]          cols;
    logic [sqerr_pkg::CNT_W-1:0]          rows;
    logic signed [GSH_W-1:0]              gsh;
    logic signed [sqerr_pkg::GRAD_W-1:0]  grad_sat;
    logic [sqerr_pkg::LOSS_W:0]           row_sum;
    logic [sqerr_pkg::LOSS_W-1:0]         row_sat;
    logic [sqerr_pkg::BATCH_W:0]          batch_sum;
    logic [sqerr_pkg::BATCH_W-1:0]        batch_sat;
    logic                                 row_end;
    logic                                 batch_end;
    logic                                 out_free;
    logic                                 in_xfer;

    // Lengths of zero count as one; oversize lengths are clamped to the maxima.
    always_comb begin
        if (r_row_length == '0) begin
            cols = sqerr_pkg::LEN_W'(1);
        end else if (r_row_length > sqerr_pkg::LEN_W'(sqerr_pkg::MAX_COLS)) begin
            cols = sqerr_pkg::LEN_W'(sqerr_pkg::MAX_COLS);
        end else begin
            cols = r_row_length;
        end
        if (r_row_count == '0) begin
            rows = sqerr_pkg::CNT_W'(1);
        end else if (r_row_count > sqerr_pkg::CNT_W'(sqerr_pkg::MAX_ROWS)) begin
            rows = sqerr_pkg::CNT_W'(sqerr_pkg::MAX_ROWS);
        end else begin
            rows = r_row_count;
        end
    end

    always_comb begin
        if (r_state == sqerr_pkg::S_GRAD) begin
            mul_b = $signed({1'b0, r_grad_scale});
        end else begin
            mul_b = sqerr_pkg::MUL_W'(r_diff);
        end
        mul_a = sqerr_pkg::MUL_W'(r_diff);
    end

    sqerr_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    sqerr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (batch_sat),
        .i_divisor  (rows),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    always_comb begin
        gsh = prod[sqerr_pkg::PROD_W-1:sqerr_pkg::FRAC_W];
        if (gsh > GSH_W'(131071)) begin
            grad_sat = sqerr_pkg::GRAD_W'(131071);
        end else if (gsh < -GSH_W'(131072)) begin
            grad_sat = -sqerr_pkg::GRAD_W'(131072);
        end else begin
            grad_sat = gsh[sqerr_pkg::GRAD_W-1:0];
        end

        row_sum = {1'b0, r_row_acc} + (sqerr_pkg::LOSS_W + 1)'(prod[sqerr_pkg::SQ_W-1:0]);
        row_sat = row_sum[sqerr_pkg::LOSS_W] ? '1 : row_sum[sqerr_pkg::LOSS_W-1:0];

        batch_sum = {1'b0, r_batch_acc} + (sqerr_pkg::BATCH_W + 1)'(r_row_loss);
        batch_sat = batch_sum[sqerr_pkg::BATCH_W] ? '1 : batch_sum[sqerr_pkg::BATCH_W-1:0];

        row_end   = ({1'b0, r_col} + sqerr_pkg::LEN_W'(1)) >= cols;
        batch_end = (sqerr_pkg::CNT_W'(r_rowp) + sqerr_pkg::CNT_W'(1)) >= rows;
    end

    assign out_free  = !r_o_valid || o_out.ready;
    assign in_xfer   = i_in.valid && (r_state == sqerr_pkg::S_IDLE);
    assign div_start = (r_state == sqerr_pkg::S_BATCH) && batch_end;

    always_comb begin
        n_state = r_state;
        case (r_state)
            sqerr_pkg::S_IDLE:  if (i_in.valid) n_state = sqerr_pkg::S_GRAD;
            sqerr_pkg::S_GRAD:  n_state = sqerr_pkg::S_SQR;
            sqerr_pkg::S_SQR:   n_state = sqerr_pkg::S_ROW;
            sqerr_pkg::S_ROW:   n_state = row_end ? sqerr_pkg::S_BATCH : sqerr_pkg::S_OUT;
            sqerr_pkg::S_BATCH: n_state = batch_end ? sqerr_pkg::S_DIV : sqerr_pkg::S_OUT;
            sqerr_pkg::S_DIV:   if (div_done) n_state = sqerr_pkg::S_OUT;
            sqerr_pkg::S_OUT:   if (out_free) n_state = sqerr_pkg::S_IDLE;
            default:            n_state = sqerr_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sqerr_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_length <= sqerr_pkg::ROW_LENGTH_RST;
            r_row_count  <= sqerr_pkg::ROW_COUNT_RST;
            r_grad_scale <= sqerr_pkg::GRAD_SCALE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sqerr_pkg::CFG_ROW_LENGTH: r_row_length <= i_cfg_data[sqerr_pkg::LEN_W-1:0];
                sqerr_pkg::CFG_ROW_COUNT:  r_row_count  <= i_cfg_data[sqerr_pkg::CNT_W-1:0];
                sqerr_pkg::CFG_GRAD_SCALE: r_grad_scale <= i_cfg_data[sqerr_pkg::SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // Running positions and sums.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_rowp      <= '0;
            r_row_acc   <= '0;
            r_batch_acc <= '0;
        end else begin
            if (r_state == sqerr_pkg::S_ROW) begin
                if (row_end) begin
                    r_col     <= '0;
                    r_row_acc <= '0;
                end else begin
                    r_col     <= r_col + sqerr_pkg::COL_W'(1);
                    r_row_acc <= row_sat;
                end
            end
            if (r_state == sqerr_pkg::S_BATCH) begin
                if (batch_end) begin
                    r_rowp      <= '0;
                    r_batch_acc <= '0;
                end else begin
                    r_rowp      <= r_rowp + sqerr_pkg::ROWP_W'(1);
                    r_batch_acc <= batch_sat;
                end
            end
        end
    end

    // Per-element working values.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_diff <= sqerr_pkg::DIFF_W'(i_in.predicted) - sqerr_pkg::DIFF_W'(i_in.target);
        end
        if (r_state == sqerr_pkg::S_SQR) begin
            r_grad <= grad_sat;
        end
        if (r_state == sqerr_pkg::S_ROW) begin
            r_row_end   <= row_end;
            r_row_loss  <= row_end ? row_sat : '0;
            r_batch_end <= 1'b0;
            r_mean      <= '0;
        end
        if (r_state == sqerr_pkg::S_BATCH) begin
            r_batch_end <= batch_end;
        end
        if (r_state == sqerr_pkg::S_DIV && div_done) begin
            if (div_quo[sqerr_pkg::BATCH_W-1:sqerr_pkg::LOSS_W] != '0) begin
                r_mean <= '1;
            end else begin
                r_mean <= div_quo[sqerr_pkg::LOSS_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_state == sqerr_pkg::S_OUT && out_free) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == sqerr_pkg::S_OUT && out_free) begin
            r_o_grad       <= r_grad;
            r_o_row_done   <= r_row_end;
            r_o_row_loss   <= r_row_loss;
            r_o_batch_done <= r_batch_end;
            r_o_mean       <= r_mean;
        end
    end

    assign i_in.ready       = (r_state == sqerr_pkg::S_IDLE);
    assign o_out.valid      = r_o_valid;
    assign o_out.gradient   = r_o_grad;
    assign o_out.row_done   = r_o_row_done;
    assign o_out.row_loss   = r_o_row_loss;
    assign o_out.batch_done = r_o_batch_done;
    assign o_out.batch_mean = r_o_mean;

endmodule
